>>> hw/rtl/mbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared widths, codes and types of the multichannel biquad cascade.
// ----------------------------------------------------------------------------
package mbc_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int CHAN_BITS        = 5;
  localparam int COEFF_FRAC_BITS  = 16;
  localparam int COEFF_BITS       = COEFF_FRAC_BITS + 2;
  localparam int NUM_STAGES       = 3;
  localparam int REG_BITS         = NUM_STAGES * COEFF_BITS;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CHANNELS_DEFAULT = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coef_t;
  typedef logic [1:0]                    stage_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;

  localparam stage_t STAGE_NOTCH    = 2'd0;
  localparam stage_t STAGE_HIGHPASS = 2'd1;
  localparam stage_t STAGE_LOWPASS  = 2'd2;

  localparam cfg_idx_t CFG_STAGE_ENABLE    = 2'd0;
  localparam cfg_idx_t CFG_NOTCH_COEFFS    = 2'd1;
  localparam cfg_idx_t CFG_HIGHPASS_COEFFS = 2'd2;
  localparam cfg_idx_t CFG_LOWPASS_COEFFS  = 2'd3;

  // h0 most recent, h1 the one before
  typedef struct packed {
    sample_t h1;
    sample_t h0;
  } hist_t;

  // hist[0] raw, [1] notch, [2] high-pass, [3] low-pass
  typedef struct packed {
    logic [NUM_STAGES-1:0][1:0] seed;
    hist_t [NUM_STAGES:0]       hist;
  } entry_t;

  typedef struct packed {
    logic   load;
    stage_t kind;
  } biq_ctrl_t;

  typedef struct packed {
    sample_t x;
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } biq_ops_t;

endpackage

>>> hw/rtl/mbc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_in_if / mbc_out_if
// Valid/ready stream interfaces for tagged samples in and filtered samples out.
// ----------------------------------------------------------------------------
interface mbc_in_if import mbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] channel;
  sample_t              sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mbc_out_if import mbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] out_channel;
  sample_t              filtered;

  modport source (output valid, output out_channel, output filtered, input ready);
  modport sink   (input valid, input out_channel, input filtered, output ready);
endinterface

>>> hw/rtl/mbc_biquad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_biquad
// Shared direct-form-I biquad: registered products, then round, shift and
// saturate. Serves all three stages in turn.
// ----------------------------------------------------------------------------
module mbc_biquad import mbc_pkg::*; (
  input  logic      clk,
  input  biq_ctrl_t ctrl,
  input  logic [REG_BITS-1:0] coeffs,
  input  biq_ops_t  ops,
  output sample_t   y
);

  localparam int A1_W   = COEFF_BITS + 2;
  localparam int PROD_W = A1_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W - COEFF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND =
    {{(ACC_W-COEFF_FRAC_BITS){1'b0}}, 1'b1, {(COEFF_FRAC_BITS-1){1'b0}}};

  coef_t a0, b1, b2;
  logic signed [A1_W-1:0]   a0_x2, b1_ext, a1;
  logic signed [PROD_W-1:0] m0, m1, m2, m3, m4;
  logic signed [PROD_W-1:0] p_r [5];
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-SAMPLE_BITS:0] top_bits;

  assign a0 = coeffs[COEFF_BITS-1:0];
  assign b1 = coeffs[2*COEFF_BITS-1:COEFF_BITS];
  assign b2 = coeffs[3*COEFF_BITS-1:2*COEFF_BITS];

  assign a0_x2  = {a0[COEFF_BITS-1], a0, 1'b0};
  assign b1_ext = {{2{b1[COEFF_BITS-1]}}, b1};

  always_comb begin
    case (ctrl.kind)
      STAGE_NOTCH:    a1 = b1_ext;
      STAGE_HIGHPASS: a1 = -a0_x2;
      STAGE_LOWPASS:  a1 = a0_x2;
      default:        a1 = '0;
    endcase
  end

  assign m0 = a0 * ops.x;
  assign m1 = a1 * ops.x1;
  assign m2 = a0 * ops.x2;
  assign m3 = b1 * ops.y1;
  assign m4 = b2 * ops.y2;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p_r[0] <= m0;
      p_r[1] <= m1;
      p_r[2] <= m2;
      p_r[3] <= m3;
      p_r[4] <= m4;
    end
  end

  assign acc = ACC_W'(p_r[0]) + ACC_W'(p_r[1]) + ACC_W'(p_r[2])
             - ACC_W'(p_r[3]) - ACC_W'(p_r[4]) + ROUND;

  assign q        = acc[ACC_W-1:COEFF_FRAC_BITS];
  assign top_bits = q[Q_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      y = q[SAMPLE_BITS-1:0];
    end else if (q[Q_W-1]) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

>>> hw/rtl/multichannel_biquad_cascade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade
// Per-channel notch, high-pass and low-pass biquad cascade on tagged samples.
// ----------------------------------------------------------------------------
// in_stream carries a channel number and a signed sample; out_stream returns
// the channel and the filtered sample, one result per input transfer, in
// order. cfg_we/cfg_index/cfg_wdata write the stage enables and the three
// packed coefficient sets; write them only while the block is idle.
// All per-channel history sits in one synchronous memory, read when the
// input transfer is taken and written back once the last stage is done.
// Each item makes three passes through the single biquad unit (products
// registered in ST_MUL, then sum, shift and saturation in ST_ACC), between
// the read and the write-back of the history memory. The result enters the
// output register together with the write-back, and the next input is
// taken only after that.
// Reset: configuration goes to zero and a clearing pass zeroes each entry of
// the history memory in turn; in_stream.ready stays low until it finishes.
// Stall: the result waits in the output register; the next item is taken
// and processed meanwhile, and holds in its final step until that register
// is free.
// ----------------------------------------------------------------------------
module multichannel_biquad_cascade import mbc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  mbc_in_if.sink              in_stream,
  mbc_out_if.source           out_stream,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [REG_BITS-1:0] cfg_wdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XW = AW + CHAN_BITS;
  localparam logic [1:0] SEED_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  // configuration
  logic [NUM_STAGES-1:0]                enable_r;
  logic [NUM_STAGES-1:0][REG_BITS-1:0]  coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      coef_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STAGE_ENABLE:    enable_r <= cfg_wdata[NUM_STAGES-1:0];
        CFG_NOTCH_COEFFS:    coef_r[STAGE_NOTCH]    <= cfg_wdata;
        CFG_HIGHPASS_COEFFS: coef_r[STAGE_HIGHPASS] <= cfg_wdata;
        CFG_LOWPASS_COEFFS:  coef_r[STAGE_LOWPASS]  <= cfg_wdata;
        default:             enable_r <= enable_r;
      endcase
    end
  end

  // history memory
  entry_t          hist_mem [CHANNELS];
  entry_t          rd_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= hist_mem[mem_raddr];
    end
  end

  // control and datapath registers
  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  stage_t                     stage_r, stage_nxt;
  logic [1:0]                 up_idx_r, up_idx_nxt;
  sample_t                    cur_r, cur_nxt;
  sample_t                    x_r, x_nxt;
  logic [CHAN_BITS-1:0]       ch_r, ch_nxt;
  logic                       ch_ok_r, ch_ok_nxt;
  hist_t [NUM_STAGES-1:0]     newh_r, newh_nxt;
  logic [NUM_STAGES-1:0][1:0] seed_r, seed_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [CHAN_BITS-1:0]       out_ch_r, out_ch_nxt;
  sample_t                    out_data_r, out_data_nxt;

  logic          in_xfer, in_ok, out_free, st_en, seeding;
  logic [XW-1:0] in_ext, cur_ext;
  logic [1:0]    stage_hist_idx, cnt;
  hist_t         up_hist, own_hist;
  sample_t       biq_y, y_stage;
  biq_ctrl_t     biq_ctrl;
  biq_ops_t      biq_ops;

  assign in_xfer  = in_stream.valid && in_stream.ready;
  assign in_ext   = {{AW{1'b0}}, in_stream.channel};
  assign cur_ext  = {{AW{1'b0}}, ch_r};
  assign in_ok    = in_ext < XW'(CHANNELS);
  assign out_free = !out_valid_r || out_stream.ready;

  assign mem_re    = in_xfer && in_ok;
  assign mem_raddr = in_ext[AW-1:0];

  assign stage_hist_idx = stage_r + 2'd1;
  assign up_hist        = rd_r.hist[up_idx_r];
  assign own_hist       = rd_r.hist[stage_hist_idx];
  assign cnt            = rd_r.seed[stage_r];
  assign st_en          = enable_r[stage_r] && ch_ok_r;
  assign seeding        = cnt < SEED_FULL;
  assign y_stage        = (st_en && !seeding) ? biq_y : cur_r;

  assign biq_ctrl.load = (state_r == ST_MUL);
  assign biq_ctrl.kind = stage_r;
  assign biq_ops.x     = cur_r;
  assign biq_ops.x1    = up_hist.h0;
  assign biq_ops.x2    = up_hist.h1;
  assign biq_ops.y1    = own_hist.h0;
  assign biq_ops.y2    = own_hist.h1;

  mbc_biquad u_biquad (
    .clk    (clk),
    .ctrl   (biq_ctrl),
    .coeffs (coef_r[stage_r]),
    .ops    (biq_ops),
    .y      (biq_y)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    stage_nxt     = stage_r;
    up_idx_nxt    = up_idx_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    ch_nxt        = ch_r;
    ch_ok_nxt     = ch_ok_r;
    newh_nxt      = newh_r;
    seed_nxt      = seed_r;
    out_valid_nxt = out_valid_r && !out_stream.ready;
    out_ch_nxt    = out_ch_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_ext[AW-1:0];
    mem_wdata.seed    = seed_r;
    mem_wdata.hist[0] = '{h1: rd_r.hist[0].h0, h0: x_r};
    mem_wdata.hist[1] = newh_r[0];
    mem_wdata.hist[2] = newh_r[1];
    mem_wdata.hist[3] = newh_r[2];

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == AW'(CHANNELS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          ch_nxt     = in_stream.channel;
          ch_ok_nxt  = in_ok;
          x_nxt      = in_stream.sample;
          cur_nxt    = in_stream.sample;
          stage_nxt  = STAGE_NOTCH;
          up_idx_nxt = '0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cur_nxt = y_stage;
        if (st_en) begin
          newh_nxt[stage_r] = '{h1: own_hist.h0, h0: y_stage};
          seed_nxt[stage_r] = seeding ? cnt + 2'd1 : cnt;
          up_idx_nxt        = stage_hist_idx;
        end else begin
          newh_nxt[stage_r] = own_hist;
          seed_nxt[stage_r] = cnt;
        end
        if (stage_r == STAGE_LOWPASS) begin
          state_nxt = ST_DONE;
        end else begin
          stage_nxt = stage_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          mem_we        = ch_ok_r;
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_data_nxt  = cur_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    stage_r    <= stage_nxt;
    up_idx_r   <= up_idx_nxt;
    cur_r      <= cur_nxt;
    x_r        <= x_nxt;
    ch_r       <= ch_nxt;
    ch_ok_r    <= ch_ok_nxt;
    newh_r     <= newh_nxt;
    seed_r     <= seed_nxt;
    out_ch_r   <= out_ch_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stream.ready        = (state_r == ST_IDLE);
  assign out_stream.valid       = out_valid_r;
  assign out_stream.out_channel = out_ch_r;
  assign out_stream.filtered    = out_data_r;

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_stream.ready)
    else $error("input taken while an item is in flight");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r && !in_stream.ready)
    else $error("traffic during clearing pass");

  a_no_oob_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR) || ch_ok_r)
    else $error("history write for an unknown channel");

  a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> mem_wdata.seed[0] != 2'd3 && mem_wdata.seed[1] != 2'd3
               && mem_wdata.seed[2] != 2'd3)
    else $error("seed count overrun");

  a_out_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_stream.valid
      && out_stream.out_channel == $past(ch_r))
    else $error("result channel mismatch");

endmodule

>>> test/multichannel_biquad_cascade_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade_tb
// Self-checking bench for the per-channel notch/high-pass/low-pass cascade.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of every channel's histories, seed
// counts and the register settings. It works out each filtered sample when
// its input transfer is taken. Each output transfer is checked in order
// against that prediction. Directed items cover the following cases:
//   - pass-through with all stages off
//   - seeding of each stage
//   - saturation with extreme coefficients
//   - stale history of a disabled stage
// Then sixteen register settings follow, each with random traffic. Random
// idling is applied on both sides, with one long output stall while the
// input keeps offering.
// ----------------------------------------------------------------------------
module multichannel_biquad_cascade_tb;
  import mbc_pkg::*;

  localparam int NCHAN         = CHANNELS_DEFAULT;
  localparam int MAX_REPORTS   = 40;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 120;
  localparam int CALM_PHASE    = 13;
  localparam int HOLD_PHASE    = 4;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;
  localparam longint  SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint  SAT_LO = -SAT_HI - 1;

  localparam logic [REG_BITS-1:0] COEF_MAX = {NUM_STAGES{18'h1ffff}};
  localparam logic [REG_BITS-1:0] COEF_MIN = {NUM_STAGES{18'h20000}};

  typedef struct packed {
    logic [CHAN_BITS-1:0] chan;
    sample_t              value;
  } result_t;

  class cascade_scoreboard;
    logic [NUM_STAGES-1:0] enables;
    logic [REG_BITS-1:0]   coeff_sets [NUM_STAGES];
    sample_t               history [NUM_STAGES+1][NCHAN][2];
    logic [1:0]            seeded [NCHAN][NUM_STAGES];
    result_t               expected_q [$];
    int                    errors;

    function new();
      enables = '0;
      errors  = 0;
      for (int s = 0; s < NUM_STAGES; s++) coeff_sets[s] = '0;
      for (int c = 0; c < NCHAN; c++) begin
        for (int s = 0; s < NUM_STAGES; s++) seeded[c][s] = '0;
        for (int k = 0; k <= NUM_STAGES; k++) begin
          history[k][c][0] = '0;
          history[k][c][1] = '0;
        end
      end
    endfunction

    function void write_reg(cfg_idx_t idx, logic [REG_BITS-1:0] d);
      case (idx)
        CFG_STAGE_ENABLE:    enables = d[NUM_STAGES-1:0];
        CFG_NOTCH_COEFFS:    coeff_sets[STAGE_NOTCH] = d;
        CFG_HIGHPASS_COEFFS: coeff_sets[STAGE_HIGHPASS] = d;
        CFG_LOWPASS_COEFFS:  coeff_sets[STAGE_LOWPASS] = d;
        default: ;
      endcase
    endfunction

    function sample_t biquad(stage_t kind, logic [REG_BITS-1:0] cs, sample_t x,
                             sample_t x1, sample_t x2, sample_t y1, sample_t y2);
      coef_t  ca0, cb1, cb2;
      longint a0, a1, b1, b2, acc;
      ca0 = cs[COEFF_BITS-1:0];
      cb1 = cs[2*COEFF_BITS-1:COEFF_BITS];
      cb2 = cs[3*COEFF_BITS-1:2*COEFF_BITS];
      a0 = ca0;
      b1 = cb1;
      b2 = cb2;
      case (kind)
        STAGE_NOTCH:    a1 = b1;
        STAGE_HIGHPASS: a1 = -2 * a0;
        default:        a1 = 2 * a0;
      endcase
      acc = a0 * x + a1 * x1 + a0 * x2 - b1 * y1 - b2 * y2
          + (longint'(1) << (COEFF_FRAC_BITS - 1));
      acc = acc >>> COEFF_FRAC_BITS;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      return sample_t'(acc);
    endfunction

    // past[0] raw, past[1..3] stage outputs, all as before this sample
    function void note_sample(logic [CHAN_BITS-1:0] ch, sample_t x);
      sample_t past [NUM_STAGES+1][2];
      sample_t cur, y;
      int      up;
      result_t r;
      for (int k = 0; k <= NUM_STAGES; k++) begin
        past[k][0] = history[k][ch][0];
        past[k][1] = history[k][ch][1];
      end
      cur = x;
      up  = 0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (enables[s]) begin
          if (seeded[ch][s] < 2) begin
            y = cur;
            seeded[ch][s] = seeded[ch][s] + 2'd1;
          end else begin
            y = biquad(stage_t'(s), coeff_sets[s], cur, past[up][0], past[up][1],
                       past[s+1][0], past[s+1][1]);
          end
          history[s+1][ch][1] = past[s+1][0];
          history[s+1][ch][0] = y;
          up  = s + 1;
          cur = y;
        end
      end
      history[0][ch][1] = past[0][0];
      history[0][ch][0] = x;
      r.chan  = ch;
      r.value = cur;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [CHAN_BITS-1:0] ch, sample_t v);
      result_t e;
      if (expected_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: transfer with nothing pending: expected none, actual ch %0d val %0d",
                   $time, ch, v);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (ch !== e.chan) begin
          if (errors < MAX_REPORTS)
            $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                     $time, e.chan, ch);
          errors++;
        end
        if (v !== e.value) begin
          if (errors < MAX_REPORTS)
            $display("%0t: filtered mismatch on ch %0d: expected %0d, actual %0d",
                     $time, e.chan, e.value, v);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [REG_BITS-1:0] cfg_wdata;

  mbc_in_if  in_if ();
  mbc_out_if out_if ();

  multichannel_biquad_cascade dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cascade_scoreboard sb;
  int                send_idle_pct = 0;
  int                sink_idle_pct = 0;
  int                holds_asked   = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.out_channel, out_if.filtered);
  end

  // output side: random back-pressure, plus long holds on request
  initial begin
    int holds_done;
    holds_done = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_asked > holds_done) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic offer(logic [CHAN_BITS-1:0] ch, sample_t s);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_sample(ch, s);
  endtask

  // wait for every pending result; each history write-back is done before its result is offered
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [REG_BITS-1:0] en_v, logic [REG_BITS-1:0] n_v,
                              logic [REG_BITS-1:0] h_v, logic [REG_BITS-1:0] l_v);
    logic [REG_BITS-1:0] vals [4];
    vals[CFG_STAGE_ENABLE]    = en_v;
    vals[CFG_NOTCH_COEFFS]    = n_v;
    vals[CFG_HIGHPASS_COEFFS] = h_v;
    vals[CFG_LOWPASS_COEFFS]  = l_v;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REG_BITS-1:0] any_coeffs();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[REG_BITS-1:0];
  endfunction

  // roughly stable poles, so that histories carry meaningful values
  function automatic logic [REG_BITS-1:0] stable_coeffs();
    int a0, b1, b2, lim;
    b2  = $urandom_range(0, 62000);
    lim = 65535 + b2;
    b1  = int'($urandom_range(0, 2 * lim)) - lim;
    a0  = int'($urandom_range(0, 40000)) - 8000;
    return {b2[COEFF_BITS-1:0], b1[COEFF_BITS-1:0], a0[COEFF_BITS-1:0]};
  endfunction

  function automatic logic [REG_BITS-1:0] pick_coeffs();
    if ($urandom_range(0, 9) < 7) return stable_coeffs();
    return any_coeffs();
  endfunction

  function automatic logic [REG_BITS-1:0] enable_word(logic [NUM_STAGES-1:0] en);
    logic [REG_BITS-1:0] junk;
    junk = any_coeffs();
    return {junk[REG_BITS-1:NUM_STAGES], en};
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      1, 2, 3, 4: return sample_t'($urandom);
      default:    return sample_t'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  initial begin
    logic [REG_BITS-1:0]   n_c, h_c, l_c;
    logic [NUM_STAGES-1:0] en;
    int                    base, span;
    sb = new();
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_STAGE_ENABLE;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.channel <= '0;
    in_if.sample  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // all stages off after reset: straight through
    offer(0, S_MIN);
    offer(31, S_MAX);
    offer(0, 0);
    offer(31, -1);
    settle();

    // notch only, extreme coefficients: seed, then saturate
    n_c = {18'h1ffff, 18'h20000, 18'h1ffff};
    h_c = stable_coeffs();
    l_c = stable_coeffs();
    program_regs(enable_word(3'b001), n_c, h_c, l_c);
    offer(7, S_MAX);
    offer(7, S_MIN);
    offer(7, S_MAX);
    offer(7, S_MIN);
    offer(7, 100);
    offer(7, -100);
    settle();

    // all on: high-pass and low-pass seed behind a running notch
    n_c = COEF_MIN;
    program_regs(enable_word(3'b111), n_c, h_c, l_c);
    offer(7, 1234);
    offer(7, -4321);
    offer(7, 20000);
    offer(7, -20000);
    offer(31, S_MAX);
    offer(31, S_MIN);
    offer(31, 0);
    settle();

    // high-pass off: low-pass fed from the notch history
    program_regs(enable_word(3'b101), n_c, h_c, l_c);
    offer(7, 500);
    offer(7, -700);
    offer(7, 900);
    settle();

    // high-pass back on with stale history, fed from raw
    program_regs(enable_word(3'b110), n_c, h_c, l_c);
    offer(7, 3000);
    offer(7, -3000);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          en = 3'b111; n_c = COEF_MAX; h_c = COEF_MAX; l_c = COEF_MAX;
        end
        1: begin
          en = 3'b111; n_c = COEF_MIN; h_c = COEF_MIN; l_c = COEF_MIN;
        end
        2: begin
          en = 3'b111; n_c = '0; h_c = '0; l_c = '0;
        end
        default: begin
          en  = ($urandom_range(0, 2) == 0) ? NUM_STAGES'($urandom) : 3'b111;
          n_c = pick_coeffs();
          h_c = pick_coeffs();
          l_c = pick_coeffs();
        end
      endcase
      program_regs(enable_word(en), n_c, h_c, l_c);

      if (ph >= CALM_PHASE) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        send_idle_pct = pick_pct();
        sink_idle_pct = pick_pct();
      end
      if (ph == HOLD_PHASE) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
        holds_asked++;
      end

      base = $urandom_range(0, NCHAN - 1);
      case ($urandom_range(0, 2))
        0:       span = 1;
        1:       span = 4;
        default: span = NCHAN;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++)
        offer(CHAN_BITS'(base + $urandom_range(0, span - 1)), random_sample());
      settle();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> multichannel_biquad_cascade.f
hw/rtl/mbc_pkg.sv
hw/rtl/mbc_ifs.sv
hw/rtl/mbc_biquad.sv
hw/rtl/multichannel_biquad_cascade.sv
test/multichannel_biquad_cascade_tb.sv
